### design/dsb_pkg.sv
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared types and constants of the delay-and-sum beamformer.
// ----------------------------------------------------------------------------
package dsb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_SQUARE,
    ST_ROOT
  } state_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ELEMENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_UM   = 3'd3;

  localparam logic [11:0] PITCH_RST        = 12'd300;
  localparam logic [7:0]  NUM_ELEMENTS_RST = 8'd128;
  localparam logic [12:0] NUM_SAMPLES_RST  = 13'd4096;
  localparam logic [31:0] SAMPLES_UM_RST   = 32'd435774;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam int SPU_FRAC = 24;
  localparam int DEPTH_W  = 18;

endpackage

### design/dsb_ram.sv
// ----------------------------------------------------------------------------
// dsb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/dsb_isqrt.sv
// ----------------------------------------------------------------------------
// dsb_isqrt
// Pipelined integer square root, one root bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module dsb_isqrt #(
  parameter int IN_W  = 42,
  parameter int TAG_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     value_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [TAG_W-1:0]    tag_o
);

  localparam int RT_W = IN_W / 2;

  logic              vld_q  [RT_W+1];
  logic [RT_W+1:0]   rem_q  [RT_W+1];
  logic [RT_W-1:0]   root_q [RT_W+1];
  logic [IN_W-1:0]   val_q  [RT_W+1];
  logic [TAG_W-1:0]  tag_q  [RT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    val_q[0]  <= value_i;
    tag_q[0]  <= tag_i;
  end

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic [RT_W+1:0] rem_sh;
    logic [RT_W+1:0] trial;
    logic            take;

    assign rem_sh = {rem_q[s][RT_W-1:0], val_q[s][IN_W-1:IN_W-2]};
    assign trial  = {root_q[s], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= take ? (rem_sh - trial) : rem_sh;
      root_q[s+1] <= {root_q[s][RT_W-2:0], take};
      val_q[s+1]  <= {val_q[s][IN_W-3:0], 2'b00};
      tag_q[s+1]  <= tag_q[s];
    end
  end

  assign valid_o = vld_q[RT_W];
  assign root_o  = root_q[RT_W];
  assign tag_o   = tag_q[RT_W];

endmodule

### design/delay_and_sum_beamformer.sv
// ----------------------------------------------------------------------------
// delay_and_sum_beamformer
// Delay-and-sum beamformer for one A-mode scanline over a sample store.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one complex sample into the sample store in the
// cycle it is taken and leaves busy low. A pixel word (mode 1) raises busy and
// walks the elements in use one per cycle through a pipeline of lateral
// offset, squares, a one-bit-per-stage square root, the delay multiply and a
// read of the single-port sample store; the sums then go through a second
// root pipeline. A pixel keeps busy high through the element walk over the one
// store port and the two root pipelines (only the magnitude root when no element
// is in use). The result shows for one cycle on result_valid_o as busy falls; it
// cannot be held off.
module delay_and_sum_beamformer #(
  parameter int MAX_ELEMENTS = 128,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dsb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode_i,
  input  logic [6:0]                     element_index_i,
  input  logic [11:0]                    sample_index_i,
  input  logic signed [15:0]             sample_real_i,
  input  logic signed [15:0]             sample_imag_i,
  input  logic [17:0]                    pixel_depth_i,
  output logic                           result_valid_o,
  output logic [22:0]                    magnitude_o,
  output logic                           out_of_range_o
);

  localparam int EW      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SW      = $clog2(MAX_SAMPLES);
  localparam int AW      = EW + SW;
  localparam int NE_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int NS_W    = $clog2(MAX_SAMPLES + 1);
  localparam int X2_W    = EW + 12;
  localparam int ZSQ_W   = 2 * dsb_pkg::DEPTH_W;
  localparam int D_IN_W  = ((2 * X2_W > ZSQ_W + 2) ? 2 * X2_W : ZSQ_W + 2) + 2;
  localparam int D_RT_W  = D_IN_W / 2;
  localparam int ZR_W    = D_RT_W + 1;
  localparam int PROD_W  = ZR_W + 32;
  localparam int IDX_W   = PROD_W - dsb_pkg::SPU_FRAC;
  localparam int SUM_W   = 16 + EW + 1;
  localparam int M_IN_W  = 2 * SUM_W;
  localparam int TAG_W   = EW + 1;

  // configuration
  logic [11:0] pitch_q;
  logic [7:0]  nel_q;
  logic [12:0] nsa_q;
  logic [31:0] spu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= dsb_pkg::PITCH_RST;
      nel_q   <= dsb_pkg::NUM_ELEMENTS_RST;
      nsa_q   <= dsb_pkg::NUM_SAMPLES_RST;
      spu_q   <= dsb_pkg::SAMPLES_UM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsb_pkg::REG_PITCH:        pitch_q <= cfg_data_i[11:0];
        dsb_pkg::REG_NUM_ELEMENTS: nel_q   <= cfg_data_i[7:0];
        dsb_pkg::REG_NUM_SAMPLES:  nsa_q   <= cfg_data_i[12:0];
        dsb_pkg::REG_SAMPLES_UM:   spu_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [NE_W-1:0] n_el;
  logic [NS_W-1:0] n_sa;
  assign n_el = (32'(nel_q) > 32'(MAX_ELEMENTS)) ? NE_W'(MAX_ELEMENTS) : NE_W'(nel_q);
  assign n_sa = (32'(nsa_q) > 32'(MAX_SAMPLES)) ? NS_W'(MAX_SAMPLES) : NS_W'(nsa_q);

  // control
  dsb_pkg::state_e state_q, state_d;
  logic accept, load_acc, pixel_acc;
  logic issue_en, square_en;
  logic acc_last;
  logic mag_vld;

  assign accept    = start && !busy;
  assign load_acc  = accept && (mode_i == dsb_pkg::MODE_LOAD);
  assign pixel_acc = accept && (mode_i == dsb_pkg::MODE_PIXEL);

  logic [EW-1:0]   n_q;
  logic [EW+1:0]   nm1;
  logic            n_last;
  assign nm1    = (EW+2)'(n_el) - (EW+2)'(1);
  assign n_last = ((EW+2)'(n_q) == nm1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dsb_pkg::ST_IDLE: begin
        if (pixel_acc) begin
          state_d = (n_el == '0) ? dsb_pkg::ST_SQUARE : dsb_pkg::ST_ISSUE;
        end
      end
      dsb_pkg::ST_ISSUE:  if (n_last) state_d = dsb_pkg::ST_DRAIN;
      dsb_pkg::ST_DRAIN:  if (acc_last) state_d = dsb_pkg::ST_SQUARE;
      dsb_pkg::ST_SQUARE: state_d = dsb_pkg::ST_ROOT;
      dsb_pkg::ST_ROOT:   if (mag_vld) state_d = dsb_pkg::ST_IDLE;
      default:            state_d = dsb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_q != dsb_pkg::ST_IDLE);
    issue_en  = (state_q == dsb_pkg::ST_ISSUE);
    square_en = (state_q == dsb_pkg::ST_SQUARE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsb_pkg::ST_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      if (pixel_acc) begin
        n_q <= '0;
      end else if (issue_en) begin
        n_q <= n_q + EW'(1);
      end
    end
  end

  logic [dsb_pkg::DEPTH_W-1:0] z_q;
  always_ff @(posedge clk_i) begin
    if (pixel_acc) begin
      z_q <= pixel_depth_i;
    end
  end

  // stage a: lateral offset magnitude
  logic [EW+1:0]  twice_n, ak_full;
  logic           a_vld_q;
  logic [EW-1:0]  a_ak_q;
  logic [TAG_W-1:0] a_tag_q;
  assign twice_n = {1'b0, n_q, 1'b0};
  assign ak_full = (twice_n >= nm1) ? (twice_n - nm1) : (nm1 - twice_n);

  // stage b, c
  logic             b_vld_q, c_vld_q;
  logic [X2_W-1:0]  b_x2_q;
  logic [TAG_W-1:0] b_tag_q, c_tag_q;
  logic [2*X2_W-1:0] c_x2sq_q;
  logic [ZSQ_W-1:0]  c_zsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= issue_en;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ak_q   <= ak_full[EW-1:0];
    a_tag_q  <= {n_last, n_q};
    b_x2_q   <= X2_W'(a_ak_q) * X2_W'(pitch_q);
    b_tag_q  <= a_tag_q;
    c_x2sq_q <= (2*X2_W)'(b_x2_q) * (2*X2_W)'(b_x2_q);
    c_zsq_q  <= ZSQ_W'(z_q) * ZSQ_W'(z_q);
    c_tag_q  <= b_tag_q;
  end

  // range root
  logic              r_vld;
  logic [D_RT_W-1:0] r_root;
  logic [TAG_W-1:0]  r_tag;

  dsb_isqrt #(
    .IN_W  (D_IN_W),
    .TAG_W (TAG_W)
  ) u_range_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .value_i (D_IN_W'(c_x2sq_q) + D_IN_W'({c_zsq_q, 2'b00})),
    .tag_i   (c_tag_q),
    .valid_o (r_vld),
    .root_o  (r_root),
    .tag_o   (r_tag)
  );

  // stage d, e: path length and delay multiply
  logic              d_vld_q, e_vld_q;
  logic [ZR_W-1:0]   d_zr_q;
  logic [PROD_W-1:0] e_prod_q;
  logic [TAG_W-1:0]  d_tag_q, e_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      d_vld_q <= r_vld;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_zr_q   <= ZR_W'(z_q) + ZR_W'(r_root >> 1);
    d_tag_q  <= r_tag;
    e_prod_q <= PROD_W'(d_zr_q) * PROD_W'(spu_q);
    e_tag_q  <= d_tag_q;
  end

  // stage f: index check and store read
  logic [IDX_W-1:0] idx;
  logic             idx_oor;
  logic             f_vld_q, f_oor_q, f_last_q;
  assign idx     = e_prod_q[PROD_W-1:dsb_pkg::SPU_FRAC];
  assign idx_oor = (idx >= IDX_W'(n_sa));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_oor_q  <= idx_oor;
    f_last_q <= e_tag_q[EW];
  end

  // sample store, single port: loads only while idle, reads only while busy
  logic [31:0] e_ext, s_ext;
  logic        load_ok;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;

  assign e_ext    = 32'(element_index_i);
  assign s_ext    = 32'(sample_index_i);
  assign load_ok  = (e_ext < 32'(MAX_ELEMENTS)) && (s_ext < 32'(MAX_SAMPLES));
  assign ram_addr = busy ? {e_tag_q[EW-1:0], idx[SW-1:0]}
                         : {e_ext[EW-1:0], s_ext[SW-1:0]};

  dsb_ram #(
    .WIDTH (32),
    .DEPTH (2**AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc && load_ok),
    .addr_i  (ram_addr),
    .wdata_i ({sample_real_i, sample_imag_i}),
    .rdata_o (ram_rdata)
  );

  // stage g: accumulate
  logic signed [SUM_W-1:0] sum_re_q, sum_im_q;
  logic                    flag_q;
  assign acc_last = f_vld_q && f_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (pixel_acc) begin
      flag_q <= 1'b0;
    end else if (f_vld_q && f_oor_q) begin
      flag_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_acc) begin
      sum_re_q <= '0;
      sum_im_q <= '0;
    end else if (f_vld_q && !f_oor_q) begin
      sum_re_q <= sum_re_q + SUM_W'(signed'(ram_rdata[31:16]));
      sum_im_q <= sum_im_q + SUM_W'(signed'(ram_rdata[15:0]));
    end
  end

  // magnitude
  logic              sq_vld_q;
  logic [M_IN_W-1:0] sq_re_q, sq_im_q;
  logic [SUM_W-1:0]  m_root;
  logic [0:0]        m_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= square_en;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_re_q <= M_IN_W'(sum_re_q * sum_re_q);
    sq_im_q <= M_IN_W'(sum_im_q * sum_im_q);
  end

  dsb_isqrt #(
    .IN_W  (M_IN_W),
    .TAG_W (1)
  ) u_mag_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld_q),
    .value_i (sq_re_q + sq_im_q),
    .tag_i   (flag_q),
    .valid_o (mag_vld),
    .root_o  (m_root),
    .tag_o   (m_tag)
  );

  logic        res_vld_q;
  logic [22:0] mag_q;
  logic        oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= mag_vld && (state_q == dsb_pkg::ST_ROOT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_vld) begin
      mag_q <= 23'(32'(m_root));
      oor_q <= m_tag[0];
    end
  end

  assign result_valid_o = res_vld_q;
  assign magnitude_o    = mag_q;
  assign out_of_range_o = oor_q;

endmodule

### design/dsb_checker.sv
// ----------------------------------------------------------------------------
// dsb_checker
// Port-level checks of the delay-and-sum beamformer, bound to the top level.
// ----------------------------------------------------------------------------
module dsb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [dsb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [dsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           start,
  input logic                           busy,
  input logic                           mode_i,
  input logic [6:0]                     element_index_i,
  input logic [11:0]                    sample_index_i,
  input logic signed [15:0]             sample_real_i,
  input logic signed [15:0]             sample_imag_i,
  input logic [17:0]                    pixel_depth_i,
  input logic                           result_valid_o,
  input logic [22:0]                    magnitude_o,
  input logic                           out_of_range_o
);

  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (mode_i == dsb_pkg::MODE_PIXEL) |=> busy)
    else $error("pixel word did not raise busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (mode_i == dsb_pkg::MODE_LOAD) |=> !busy)
    else $error("load word raised busy");

  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("pixel ended without a result");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && !$past(result_valid_o))
    else $error("result outside the end of a pixel");

endmodule

bind delay_and_sum_beamformer dsb_checker u_dsb_checker (.*);
